// ----- hw/rtl/command_line_editor_defines.svh -----
// Assertion macros for the command line editor.
// Used by the top level; no other dependencies.
`ifndef COMMAND_LINE_EDITOR_DEFINES_SVH
`define COMMAND_LINE_EDITOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define CLE_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("command_line_editor check failed");
`define CLE_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk) prop) \
	else $error("command_line_editor reset check failed");
`else
`define CLE_ASSERT(lbl, prop)
`define CLE_ASSERT_RST(lbl, prop)
`endif
`endif

// ----- hw/rtl/cle_pkg.sv -----
// Shared types and constants of the command line editor.
// No dependencies.
package cle_pkg;
	localparam int LINE_BYTES = 64;
	localparam int IDX_W = $clog2(LINE_BYTES);
	localparam logic [7:0] SPACE_CODE = 8'd32;

	localparam logic [1:0] REQ_CHAR = 2'd0;
	localparam logic [1:0] REQ_PRESS = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;

	localparam logic [3:0] KEY_LEFT = 4'd2;
	localparam logic [3:0] KEY_RIGHT = 4'd3;
	localparam logic [3:0] KEY_BACK = 4'd4;
	localparam logic [3:0] KEY_DELETE = 4'd5;
	localparam logic [3:0] KEY_INSERT = 4'd6;
	localparam logic [3:0] KEY_UP = 4'd7;
	localparam logic [3:0] KEY_DOWN = 4'd8;
	localparam logic [3:0] KEY_RETURN = 4'd9;
	localparam logic [3:0] KEY_CONTROL = 4'd10;
	localparam logic [3:0] KEY_HOME = 4'd11;
	localparam logic [3:0] KEY_END = 4'd12;

	typedef enum logic [1:0] {CELL_HOLD, CELL_LEFT, CELL_RIGHT, CELL_WRITE} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		logic [7:0] wdata;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EMIT, ST_WR1, ST_WR2, ST_WL1, ST_WL2, ST_STREAM
	} state_t;
endpackage

// ----- hw/rtl/command_line_editor.sv -----
// Command line editor: single-line buffer held in a chain of character cells.
// Simple events pass through ST_EMIT; word moves first walk ST_WR1/ST_WR2 or ST_WL1/ST_WL2.
// Return streams one committed character per cycle while the output is not stalled.
// One request at a time: a new request is taken only once the editor is back in ST_IDLE.
// Reset: arst_n clears the buffer, cursor, length, modes and scroll at once.
`include "command_line_editor_defines.svh"
module command_line_editor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // char_code[7:0], key_class[11:8], zero[15:12]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// consumed[0] cursor[6:1] length[12:7] overstrike_on[13] ctrl_held[14]
	// scroll[22:15] committed[23] line_char[31:24]
	output logic [31:0] m_tdata,
	output logic        m_tlast
);
	import cle_pkg::*;

	localparam logic [IDX_W-1:0] MAX_LEN = IDX_W'(LINE_BYTES - 1);

	state_t state_q, state_d;
	logic [IDX_W-1:0] cursor_q, length_q, cnt_q;
	logic overstrike_q, ctrl_q, consumed_q;
	logic signed [7:0] scroll_q;
	logic signed [IDX_W+1:0] p_q;
	logic [7:0] cell_q [LINE_BYTES];
	cell_ctl_t ctl [LINE_BYTES];
	logic [LINE_BYTES-1:0] sp;

	logic [1:0] req_type;
	logic [7:0] char_code;
	logic [3:0] key_class;
	logic accept, slot_free, emit;
	logic ins_op, del_op, ovr_op, shift_op;
	logic [IDX_W-1:0] del_pos;
	logic p_in, p_nonneg, sp_p;

	assign req_type = s_tuser;
	assign char_code = s_tdata[7:0];
	assign key_class = s_tdata[11:8];
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign slot_free = !m_tvalid || m_tready;

	genvar g;
	generate
		for (g = 0; g < LINE_BYTES; g++) begin : g_cell
			logic [7:0] left_d, right_d;
			if (g == 0) begin : g_l0
				assign left_d = '0;
			end else begin : g_ln
				assign left_d = cell_q[g-1];
			end
			if (g == LINE_BYTES - 1) begin : g_rl
				assign right_d = '0;
			end else begin : g_rn
				assign right_d = cell_q[g+1];
			end
			assign sp[g] = (cell_q[g] == SPACE_CODE);
			cle_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl[g]),
				.left_d(left_d), .right_d(right_d), .data_q(cell_q[g])
			);
		end
	endgenerate

	// decode of buffer edits for the accepted request and of the shift for the return stream
	always_comb begin
		ins_op = 1'b0;
		ovr_op = 1'b0;
		del_op = 1'b0;
		del_pos = cursor_q;
		if (accept && req_type == REQ_CHAR && char_code >= 8'd32 && char_code <= 8'd127) begin
			if (overstrike_q) ovr_op = (cursor_q != MAX_LEN);
			else ins_op = (length_q != MAX_LEN);
		end
		if (accept && req_type == REQ_PRESS) begin
			if (key_class == KEY_BACK && cursor_q != '0) begin
				del_op = 1'b1;
				del_pos = cursor_q - 1'b1;
			end
			if (key_class == KEY_DELETE && cursor_q < length_q) del_op = 1'b1;
		end
		shift_op = (state_q == ST_STREAM) && slot_free;
		for (int i = 0; i < LINE_BYTES; i++) begin
			ctl[i].op = CELL_HOLD;
			ctl[i].wdata = char_code;
			if (shift_op) ctl[i].op = CELL_RIGHT;
			if (del_op && IDX_W'(i) >= del_pos) ctl[i].op = CELL_RIGHT;
			if ((ins_op || ovr_op) && IDX_W'(i) == cursor_q) ctl[i].op = CELL_WRITE;
			if (ins_op && IDX_W'(i) > cursor_q && IDX_W'(i) <= length_q) ctl[i].op = CELL_LEFT;
		end
	end

	// word-walk pointer tests
	assign p_in = (p_q >= 0) && (p_q < $signed({2'b00, length_q}));
	assign p_nonneg = (p_q >= 0);
	assign sp_p = sp[p_q[IDX_W-1:0]];

	always_comb begin
		state_d = state_q;
		emit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_PRESS && key_class == KEY_RETURN) state_d = ST_STREAM;
					else if (req_type == REQ_PRESS && ctrl_q && key_class == KEY_LEFT)
						state_d = ST_WL1;
					else if (req_type == REQ_PRESS && ctrl_q && key_class == KEY_RIGHT)
						state_d = ST_WR1;
					else state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_WR1: if (!(p_in && sp_p)) state_d = ST_WR2;
			ST_WR2: if (!(p_in && !sp_p)) state_d = ST_EMIT;
			ST_WL1: if (!(p_nonneg && sp_p)) state_d = ST_WL2;
			ST_WL2: if (!(p_nonneg && !sp_p)) state_d = ST_EMIT;
			ST_STREAM: if (slot_free && cnt_q <= IDX_W'(1)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			length_q <= '0;
			overstrike_q <= 1'b0;
			ctrl_q <= 1'b0;
			scroll_q <= '0;
			consumed_q <= 1'b0;
			cnt_q <= '0;
			p_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tlast <= 1'b0;
		end else begin
			if (emit || shift_op) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			if (accept) begin
				if (req_type == REQ_CHAR)
					consumed_q <= (char_code >= 8'd32 && char_code <= 8'd127);
				else if (req_type == REQ_PRESS || req_type == REQ_RELEASE)
					consumed_q <= (key_class >= 4'd1 && key_class <= KEY_END);
				else
					consumed_q <= 1'b0;
				if (req_type == REQ_CHAR && char_code >= 8'd32 && char_code <= 8'd127) begin
					if (ins_op || ovr_op) begin
						cursor_q <= cursor_q + 1'b1;
						if (ins_op || cursor_q == length_q) length_q <= length_q + 1'b1;
					end
				end
				if (req_type == REQ_RELEASE && key_class == KEY_CONTROL) ctrl_q <= 1'b0;
				if (req_type == REQ_PRESS) begin
					case (key_class)
						KEY_LEFT: begin
							p_q <= $signed({2'b00, cursor_q}) - 8'sd1;
							if (!ctrl_q && cursor_q != '0) cursor_q <= cursor_q - 1'b1;
						end
						KEY_RIGHT: begin
							p_q <= $signed({2'b00, cursor_q}) + 8'sd1;
							if (!ctrl_q && cursor_q < length_q) cursor_q <= cursor_q + 1'b1;
						end
						KEY_BACK: begin
							if (del_op) begin
								cursor_q <= del_pos;
								length_q <= length_q - 1'b1;
							end
						end
						KEY_DELETE: if (del_op) length_q <= length_q - 1'b1;
						KEY_INSERT: overstrike_q <= !overstrike_q;
						KEY_UP: if (ctrl_q && scroll_q != 8'sd127) scroll_q <= scroll_q + 8'sd1;
						KEY_DOWN: if (ctrl_q && scroll_q != -8'sd128) scroll_q <= scroll_q - 8'sd1;
						KEY_RETURN: begin
							cnt_q <= length_q;
							cursor_q <= '0;
							length_q <= '0;
							scroll_q <= '0;
						end
						KEY_CONTROL: ctrl_q <= 1'b1;
						KEY_HOME: cursor_q <= '0;
						KEY_END: cursor_q <= length_q;
						default: ;
					endcase
				end
			end
			case (state_q)
				ST_WR1: p_q <= p_q + 8'sd1;
				ST_WR2: begin
					p_q <= p_q + 8'sd1;
					if (!(p_in && !sp_p))
						cursor_q <= (p_q > $signed({2'b00, length_q})) ? length_q
							: p_q[IDX_W-1:0];
				end
				ST_WL1: p_q <= p_q - 8'sd1;
				ST_WL2: begin
					p_q <= p_q - 8'sd1;
					if (!(p_nonneg && !sp_p))
						cursor_q <= p_nonneg ? p_q[IDX_W-1:0] : '0;
				end
				default: ;
			endcase
			if (emit) begin
				m_tlast <= 1'b1;
				m_tdata <= {8'd0, 1'b0, scroll_q, ctrl_q, overstrike_q,
					length_q, cursor_q, consumed_q};
			end
			if (shift_op) begin
				m_tlast <= (cnt_q <= IDX_W'(1));
				m_tdata <= {cell_q[0], 1'b1, scroll_q, ctrl_q, overstrike_q,
					length_q, cursor_q, 1'b1};
				if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`CLE_ASSERT(a_cursor_in_line, cursor_q <= length_q)
	`CLE_ASSERT(a_length_max, length_q <= MAX_LEN)
	`CLE_ASSERT(a_busy_no_ready, (state_q != ST_IDLE) |-> !s_tready)
	`CLE_ASSERT_RST(a_reset_empty, !arst_n |=> (length_q == '0 || !$past(arst_n)))
endmodule

// ----- hw/rtl/cle_cell.sv -----
// One character slot of the line buffer chain.
// Depends on cle_pkg.
module cle_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  cle_pkg::cell_ctl_t ctl,
	input  logic [7:0]        left_d,
	input  logic [7:0]        right_d,
	output logic [7:0]        data_q
);
	import cle_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			case (ctl.op)
				CELL_LEFT:  data_q <= left_d;
				CELL_RIGHT: data_q <= right_d;
				CELL_WRITE: data_q <= ctl.wdata;
				default:    data_q <= data_q;
			endcase
		end
	end
endmodule

// ----- sim/command_line_editor_checker.sv -----
// Checker for the command line editor: watches both stream channels, predicts
// each result from the accepted requests and compares each whole result. Uses cle_pkg.
`timescale 1ns / 100ps
module command_line_editor_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending,
	output int          result_count,
	output int          commit_count
);
	import cle_pkg::*;

	typedef struct packed {
		logic       last;
		logic [7:0] line_char;
		logic       committed;
		logic [7:0] scroll;
		logic       ctrl_held;
		logic       overstrike_on;
		logic [5:0] length;
		logic [5:0] cursor;
		logic       consumed;
	} edit_result_t;

	logic [7:0] text [LINE_BYTES];
	int         cur, len, scr;
	logic       ovr, ctl;
	edit_result_t expected_results[$];

	function automatic edit_result_t snapshot(logic used, logic com, logic [7:0] ch, logic fin);
		edit_result_t r;
		r.consumed = used;
		r.cursor = cur[5:0];
		r.length = len[5:0];
		r.overstrike_on = ovr;
		r.ctrl_held = ctl;
		r.scroll = scr[7:0];
		r.committed = com;
		r.line_char = ch;
		r.last = fin;
		return r;
	endfunction

	task automatic drop_char(input int pos);
		if (pos < len) begin
			for (int i = pos; i + 1 < len; i++)
				text[i] = text[i + 1];
			text[len - 1] = 8'd0;
			len--;
		end
	endtask

	task automatic apply_edit(input logic [1:0] req, input logic [7:0] ch, input logic [3:0] key);
		logic used;
		int p;
		logic [7:0] saved [LINE_BYTES];
		int n;
		used = 1'b0;
		if (req == REQ_CHAR) begin
			if (ch >= 8'd32 && ch <= 8'd127) begin
				used = 1'b1;
				if (ovr) begin
					if (cur < LINE_BYTES - 1) begin
						text[cur] = ch;
						if (cur == len) len++;
						cur++;
					end
				end else if (len + 2 <= LINE_BYTES) begin
					for (int i = len; i > cur; i--)
						text[i] = text[i - 1];
					text[cur] = ch;
					len++;
					cur++;
				end
			end
		end else if (req == REQ_PRESS) begin
			used = key >= 4'd1 && key <= 4'd12;
			case (key)
				KEY_LEFT: begin
					if (ctl) begin
						p = cur;
						do p--; while (p >= 0 && text[p] == SPACE_CODE);
						do p--; while (p >= 0 && text[p] != SPACE_CODE);
						cur = p < 0 ? 0 : p;
					end else if (cur > 0) cur--;
				end
				KEY_RIGHT: begin
					if (ctl) begin
						p = cur;
						do p++; while (p < len && text[p] == SPACE_CODE);
						do p++; while (p < len && text[p] != SPACE_CODE);
						cur = p > len ? len : p;
					end else if (cur < len) cur++;
				end
				KEY_BACK: begin
					if (cur > 0) begin
						cur--;
						drop_char(cur);
					end
				end
				KEY_DELETE: drop_char(cur);
				KEY_INSERT: ovr = !ovr;
				KEY_UP: if (ctl && scr < 127) scr++;
				KEY_DOWN: if (ctl && scr > -128) scr--;
				KEY_RETURN: begin
					saved = text;
					n = len;
					foreach (text[i]) text[i] = 8'd0;
					cur = 0;
					len = 0;
					scr = 0;
					if (n == 0)
						expected_results.push_back(snapshot(1'b1, 1'b1, 8'd0, 1'b1));
					for (int i = 0; i < n; i++)
						expected_results.push_back(snapshot(1'b1, 1'b1, saved[i], i + 1 == n));
					return;
				end
				KEY_CONTROL: ctl = 1'b1;
				KEY_HOME: cur = 0;
				KEY_END: cur = len;
				default: ;
			endcase
		end else if (req == REQ_RELEASE) begin
			used = key >= 4'd1 && key <= 4'd12;
			if (key == KEY_CONTROL) ctl = 1'b0;
		end
		expected_results.push_back(snapshot(used, 1'b0, 8'd0, 1'b1));
	endtask

	always @(posedge clk or negedge arst_n) begin
		edit_result_t got, exp_r;
		if (!arst_n) begin
			foreach (text[i]) text[i] = 8'd0;
			cur = 0;
			len = 0;
			scr = 0;
			ovr = 1'b0;
			ctl = 1'b0;
			expected_results.delete();
			fail_count <= 0;
			result_count <= 0;
			commit_count <= 0;
			pending <= 0;
		end else begin
			// output side first: a request is never answered in the cycle it is accepted
			if (m_tvalid && m_tready) begin
				got = {m_tlast, m_tdata[31:0]};
				result_count <= result_count + 1;
				if (got.committed) commit_count <= commit_count + 1;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (got != exp_r) begin
						$display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				apply_edit(s_tuser, s_tdata[7:0], s_tdata[11:8]);
			pending <= expected_results.size();
		end
	end
endmodule

// ----- sim/command_line_editor_test.sv -----
// Testbench top for the command line editor: clock, reset, request stimulus
// with random idling, verdict. Uses cle_pkg and command_line_editor_checker.
`timescale 1ns / 100ps
module command_line_editor_test;
	import cle_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	int          fail_count, pending, result_count, commit_count;
	bit          calm = 1'b0;
	int          idle_cycles = 0;
	int          sent = 0;

	always #4 clk = ~clk;

	command_line_editor dut (.*);
	command_line_editor_checker checker_i (.*);

	// receiver stalls in bursts
	always @(posedge clk) begin
		int stall;
		if (!calm && $urandom_range(0, 7) == 0) begin
			stall = $urandom_range(1, 14);
			m_tready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
		m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 4000) begin
			$display("watchdog expired");
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send(input logic [1:0] req, input logic [7:0] ch, input logic [3:0] key);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {4'd0, key, ch};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic key_tap(input logic [3:0] key);
		send(REQ_PRESS, 8'd0, key);
		send(REQ_RELEASE, 8'd0, key);
	endtask

	task automatic random_request();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			send(REQ_CHAR, ($urandom_range(0, 3) == 0) ? 8'd32 : 8'($urandom_range(33, 127)),
				4'($urandom));
		else if (pick < 50)
			send(REQ_CHAR, 8'($urandom), 4'($urandom));
		else if (pick < 85)
			send(REQ_PRESS, 8'($urandom), 4'($urandom_range(1, 12)));
		else if (pick < 95)
			send(REQ_RELEASE, 8'($urandom), 4'($urandom_range(1, 12)));
		else
			send(2'($urandom_range(0, 3)), 8'($urandom), 4'($urandom));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: character extremes, most keys, out-of-range key codes, empty return
		send(REQ_PRESS, 8'd0, KEY_RETURN);
		send(REQ_CHAR, 8'd31, 4'd0);
		send(REQ_CHAR, 8'd128, 4'd15);
		send(REQ_CHAR, 8'd255, 4'd0);
		send(REQ_CHAR, 8'd32, 4'd0);
		send(REQ_CHAR, 8'd127, 4'd0);
		send(REQ_CHAR, 8'd65, 4'd0);
		key_tap(KEY_LEFT);
		key_tap(KEY_BACK);
		key_tap(KEY_DELETE);
		key_tap(KEY_HOME);
		key_tap(KEY_BACK);
		key_tap(KEY_END);
		key_tap(KEY_DELETE);
		send(REQ_PRESS, 8'd0, KEY_UP);
		send(REQ_PRESS, 8'd0, 4'd0);
		send(REQ_PRESS, 8'd0, 4'd13);
		send(REQ_PRESS, 8'd0, 4'd1);
		send(2'd3, 8'd65, 4'd9);
		key_tap(KEY_INSERT);
		send(REQ_PRESS, 8'd0, KEY_RETURN);
		// overstrike fill up to the terminator slot, word moves, then a full-line insert
		for (int i = 0; i < 64; i++) send(REQ_CHAR, (i % 5 == 4) ? 8'd32 : 8'd97, 4'd0);
		send(REQ_PRESS, 8'd0, KEY_CONTROL);
		repeat (3) send(REQ_PRESS, 8'd0, KEY_LEFT);
		repeat (3) send(REQ_PRESS, 8'd0, KEY_RIGHT);
		send(REQ_RELEASE, 8'd0, KEY_CONTROL);
		send(REQ_PRESS, 8'd0, KEY_HOME);
		send(REQ_CHAR, 8'd98, 4'd0);
		key_tap(KEY_INSERT);
		send(REQ_CHAR, 8'd99, 4'd0);
		send(REQ_PRESS, 8'd0, KEY_RETURN);
		// scroll saturation both ways
		send(REQ_PRESS, 8'd0, KEY_CONTROL);
		repeat (129) send(REQ_PRESS, 8'd0, KEY_UP);
		send(REQ_PRESS, 8'd0, KEY_RETURN);
		repeat (129) send(REQ_PRESS, 8'd0, KEY_DOWN);
		send(REQ_RELEASE, 8'd0, KEY_CONTROL);
		send(REQ_PRESS, 8'd0, KEY_RETURN);
		// random: mostly typing and editing, returns now and then
		for (int i = 0; i < 24; i++) begin
			if (i == 14) calm = 1'b1;
			random_request();
		end
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		$display("sent %0d requests, checked %0d results, %0d committed characters",
			sent, result_count, commit_count);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/cle_pkg.sv
hw/rtl/cle_cell.sv
hw/rtl/command_line_editor.sv
sim/command_line_editor_checker.sv
sim/command_line_editor_test.sv
